// ===== hw/rtl/sse_enc_pkg.sv =====
package sse_enc_pkg;

    localparam int MAX_BYTES = 10;
    localparam int LEN_W     = 4;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [4:0] {
        OP_PUSH       = 5'd0,
        OP_POP        = 5'd1,
        OP_MOVABS     = 5'd2,
        OP_MOV        = 5'd3,
        OP_SUB        = 5'd4,
        OP_MOVQ_ST    = 5'd5,
        OP_MOVQ_LD    = 5'd6,
        OP_MOVQ_XG    = 5'd7,
        OP_MOVSD_R    = 5'd8,
        OP_ADDSD_R    = 5'd9,
        OP_SUBSD_R    = 5'd10,
        OP_MULSD_R    = 5'd11,
        OP_DIVSD_R    = 5'd12,
        OP_MOVSD_C    = 5'd13,
        OP_ADDSD_C    = 5'd14,
        OP_SUBSD_C    = 5'd15,
        OP_MULSD_C    = 5'd16,
        OP_DIVSD_C    = 5'd17,
        OP_PXOR       = 5'd18,
        OP_UCOMISD_R  = 5'd19,
        OP_UCOMISD_C  = 5'd20,
        OP_JMP8       = 5'd21,
        OP_JMP32      = 5'd22,
        OP_JZ8        = 5'd23,
        OP_JZ32       = 5'd24,
        OP_RET        = 5'd25
    } op_t;

    // one encoded instruction
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        len_t                      len;
        logic                      err;
    } enc_word_t;

    localparam byte_t REX_W      = 8'h48;
    localparam byte_t PFX_66     = 8'h66;
    localparam byte_t PFX_F2     = 8'hF2;
    localparam byte_t PFX_F3     = 8'hF3;
    localparam byte_t ESC_0F     = 8'h0F;
    localparam byte_t SIB_RSP    = 8'h24;

    // scalar-double opcode by operation within its group of five
    function automatic byte_t sd_opcode(input logic [2:0] sel);
        byte_t r;
        case (sel)
            3'd0:    r = 8'h10;
            3'd1:    r = 8'h58;
            3'd2:    r = 8'h5C;
            3'd3:    r = 8'h59;
            3'd4:    r = 8'h5E;
            default: r = 8'h10;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/sse2_scalar_instruction_encoder.sv =====
// Encodes one x86-64 instruction request per input word into its machine-code
// bytes, sent out one byte per output word in memory order with last_byte on
// the final one; a request that cannot be encoded gives a single zero byte with
// range_error set. The output lane is a single byte wide, so an instruction
// occupies it for as many output words as it has bytes (1 to 10). Requests are
// registered in a hold register, then loaded into the serializer's word
// register, so a new request can be taken while the previous one is being sent.
module sse2_scalar_instruction_encoder
    import sse_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  operation,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [63:0] immediate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        range_error
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [4:0]  op_reg;
    logic [2:0]  ra_reg;
    logic [2:0]  rb_reg;
    logic [63:0] imm_reg;
    logic        load_ready;
    logic        in_take;
    enc_word_t   enc_word;

    assign in_stall = hold_valid_reg && !load_ready;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (load_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            ra_reg  <= reg_a;
            rb_reg  <= reg_b;
            imm_reg <= immediate;
        end
    end

    sse_enc_core u_core (
        .operation (op_reg),
        .reg_a     (ra_reg),
        .reg_b     (rb_reg),
        .immediate (imm_reg),
        .word      (enc_word)
    );

    sse_enc_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (hold_valid_reg),
        .load_word   (enc_word),
        .load_ready  (load_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte),
        .range_error (range_error)
    );

endmodule

// ===== hw/rtl/sse_enc_core.sv =====
module sse_enc_core
    import sse_enc_pkg::*;
(
    input  logic [4:0]  operation,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [63:0] immediate,
    output enc_word_t   word
);

    logic       imm_gt32;
    logic       imm_le7f;
    logic       imm_zero;
    logic       idx_gt31;
    logic       idx_le15;
    logic [4:0] op_low;
    logic [2:0] sd_sel;
    byte_t      cdisp;

    assign imm_gt32 = |immediate[63:31];
    assign imm_le7f = ~|immediate[63:7];
    assign imm_zero = ~|immediate;
    assign idx_gt31 = |immediate[63:5];
    assign idx_le15 = ~immediate[4];
    assign cdisp    = {immediate[4:0], 3'b000};
    assign op_low   = (operation >= OP_MOVSD_C) ? operation - OP_MOVSD_C
                                                : operation - OP_MOVSD_R;
    assign sd_sel   = op_low[2:0];

    always_comb
    begin
        word       = '0;
        word.len   = len_t'(1);
        unique case (operation) inside
            OP_PUSH:
            begin
                word.bytes[0] = {5'b01010, reg_a};
            end
            OP_POP:
            begin
                word.bytes[0] = {5'b01011, reg_a};
            end
            OP_MOVABS:
            begin
                word.bytes[0] = REX_W;
                word.bytes[1] = 8'hB8;
                for (int i = 0; i < 8; i++)
                begin
                    word.bytes[2+i] = immediate[8*i +: 8];
                end
                word.len = len_t'(10);
            end
            OP_MOV:
            begin
                word.bytes[0] = REX_W;
                word.bytes[1] = 8'h89;
                word.bytes[2] = {2'b11, reg_b, reg_a};
                word.len      = len_t'(3);
            end
            OP_SUB:
            begin
                word.bytes[0] = REX_W;
                if (imm_gt32)
                begin
                    word.err      = 1'b1;
                    word.bytes[0] = 8'h00;
                end
                else if (imm_le7f)
                begin
                    word.bytes[1] = 8'h83;
                    word.bytes[2] = {5'b11101, reg_a};
                    word.bytes[3] = immediate[7:0];
                    word.len      = len_t'(4);
                end
                else if (reg_a == 3'd0)
                begin
                    word.bytes[1] = 8'h2D;
                    for (int i = 0; i < 4; i++)
                    begin
                        word.bytes[2+i] = immediate[8*i +: 8];
                    end
                    word.len = len_t'(6);
                end
                else
                begin
                    word.bytes[1] = 8'h81;
                    word.bytes[2] = {5'b11101, reg_a};
                    for (int i = 0; i < 4; i++)
                    begin
                        word.bytes[3+i] = immediate[8*i +: 8];
                    end
                    word.len = len_t'(7);
                end
            end
            OP_MOVQ_ST, OP_MOVQ_LD:
            begin
                if (imm_gt32)
                begin
                    word.err = 1'b1;
                end
                else
                begin
                    if (operation == OP_MOVQ_ST)
                    begin
                        word.bytes[0] = PFX_66;
                        word.bytes[2] = 8'hD6;
                    end
                    else
                    begin
                        word.bytes[0] = PFX_F3;
                        word.bytes[2] = 8'h7E;
                    end
                    word.bytes[1] = ESC_0F;
                    word.bytes[4] = SIB_RSP;
                    if (imm_zero)
                    begin
                        word.bytes[3] = {2'b00, reg_a, 3'b100};
                        word.len      = len_t'(5);
                    end
                    else if (imm_le7f)
                    begin
                        word.bytes[3] = {2'b01, reg_a, 3'b100};
                        word.bytes[5] = immediate[7:0];
                        word.len      = len_t'(6);
                    end
                    else
                    begin
                        word.bytes[3] = {2'b10, reg_a, 3'b100};
                        for (int i = 0; i < 4; i++)
                        begin
                            word.bytes[5+i] = immediate[8*i +: 8];
                        end
                        word.len = len_t'(9);
                    end
                end
            end
            OP_MOVQ_XG:
            begin
                word.bytes[0] = PFX_66;
                word.bytes[1] = REX_W;
                word.bytes[2] = ESC_0F;
                word.bytes[3] = 8'h7E;
                word.bytes[4] = {2'b11, reg_b, reg_a};
                word.len      = len_t'(5);
            end
            OP_MOVSD_R, OP_ADDSD_R, OP_SUBSD_R, OP_MULSD_R, OP_DIVSD_R,
            OP_PXOR, OP_UCOMISD_R:
            begin
                word.bytes[1] = ESC_0F;
                word.bytes[3] = {2'b11, reg_a, reg_b};
                word.len      = len_t'(4);
                if (operation == OP_PXOR)
                begin
                    word.bytes[0] = PFX_66;
                    word.bytes[2] = 8'hEF;
                end
                else if (operation == OP_UCOMISD_R)
                begin
                    word.bytes[0] = PFX_66;
                    word.bytes[2] = 8'h2E;
                end
                else
                begin
                    word.bytes[0] = PFX_F2;
                    word.bytes[2] = sd_opcode(sd_sel);
                end
            end
            OP_MOVSD_C, OP_ADDSD_C, OP_SUBSD_C, OP_MULSD_C, OP_DIVSD_C,
            OP_UCOMISD_C:
            begin
                if (idx_gt31)
                begin
                    word.err = 1'b1;
                end
                else
                begin
                    word.bytes[1] = ESC_0F;
                    if (operation == OP_UCOMISD_C)
                    begin
                        word.bytes[0] = PFX_66;
                        word.bytes[2] = 8'h2E;
                    end
                    else
                    begin
                        word.bytes[0] = PFX_F2;
                        word.bytes[2] = sd_opcode(sd_sel);
                    end
                    if (imm_zero)
                    begin
                        word.bytes[3] = {2'b00, reg_a, 3'b001};
                        word.len      = len_t'(4);
                    end
                    else if (idx_le15)
                    begin
                        word.bytes[3] = {2'b01, reg_a, 3'b001};
                        word.bytes[4] = cdisp;
                        word.len      = len_t'(5);
                    end
                    else
                    begin
                        word.bytes[3] = {2'b10, reg_a, 3'b001};
                        word.bytes[4] = cdisp;
                        word.len      = len_t'(8);
                    end
                end
            end
            OP_JMP8:
            begin
                word.bytes[0] = 8'hEB;
                word.bytes[1] = immediate[7:0];
                word.len      = len_t'(2);
            end
            OP_JMP32:
            begin
                word.bytes[0] = 8'hE9;
                for (int i = 0; i < 4; i++)
                begin
                    word.bytes[1+i] = immediate[8*i +: 8];
                end
                word.len = len_t'(5);
            end
            OP_JZ8:
            begin
                word.bytes[0] = 8'h74;
                word.bytes[1] = immediate[7:0];
                word.len      = len_t'(2);
            end
            OP_JZ32:
            begin
                word.bytes[0] = ESC_0F;
                word.bytes[1] = 8'h84;
                for (int i = 0; i < 4; i++)
                begin
                    word.bytes[2+i] = immediate[8*i +: 8];
                end
                word.len = len_t'(6);
            end
            OP_RET:
            begin
                word.bytes[0] = 8'hC3;
            end
            default:
            begin
                word.err = 1'b1;
            end
        endcase
        if (word.err)
        begin
            word.bytes = '0;
            word.len   = len_t'(1);
        end
    end

endmodule

// ===== hw/rtl/sse_enc_ser.sv =====
module sse_enc_ser
    import sse_enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_valid,
    input  enc_word_t load_word,
    output logic      load_ready,
    output logic      out_valid,
    input  logic      out_stall,
    output logic [7:0] out_byte,
    output logic      last_byte,
    output logic      range_error
);

    logic      valid_reg;
    logic      valid_next;
    len_t      idx_reg;
    len_t      idx_next;
    enc_word_t word_reg;
    logic      take;
    logic      done;

    assign out_valid   = valid_reg;
    assign out_byte    = word_reg.bytes[idx_reg];
    assign last_byte   = (idx_reg == word_reg.len - len_t'(1));
    assign range_error = word_reg.err;

    assign take       = valid_reg && !out_stall;
    assign done       = take && last_byte;
    assign load_ready = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load_ready && load_valid)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + len_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            word_reg <= load_word;
        end
    end

endmodule
